/* hw/rtl/scrp_pkg.sv */
// Package with the transaction types, state type and codes of the configuration port.
`default_nettype none

package scrp_pkg;

	// Direction of one bus byte.
	localparam logic FUNC_RECEIVE  = 1'b0;
	localparam logic FUNC_TRANSMIT = 1'b1;

	// Setting selector codes carried by the first written byte.
	localparam logic [7:0] ITEM_NONE     = 8'd0;
	localparam logic [7:0] ITEM_CLK_CAL  = 8'd1;
	localparam logic [7:0] ITEM_WR_EN    = 8'd2;
	localparam logic [7:0] ITEM_DEBUG    = 8'd3;
	localparam logic [7:0] ITEM_TIMEOUT  = 8'd4;

	// Byte counts at which a value and its complement are complete, and the byte counter's saturation limit.
	localparam logic [2:0] SHORT_LEN = 3'd2;
	localparam logic [2:0] LONG_LEN  = 3'd4;
	localparam logic [2:0] COUNT_MAX = 3'd7;

	// Largest legal values of the narrow settings.
	localparam logic [7:0] WR_EN_MAX = 8'd1;
	localparam logic [7:0] DEBUG_MAX = 8'd2;

	typedef struct packed {
		logic       func;
		logic       start_req;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        committed;
		logic [7:0]  clock_cal;
		logic        eeprom_write_enable;
		logic [1:0]  debug_mode;
		logic [15:0] tx_timeout;
	} out_t;

	typedef struct packed {
		logic [7:0]       selected_item;
		logic [2:0]       byte_count;
		logic [3:0][7:0]  byte_buffer;
		logic [7:0]       clock_cal_value;
		logic             write_enable_flag;
		logic [1:0]       debug_code;
		logic [15:0]      timeout_value;
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/scrp_core.sv */
// Next-state and result logic for one byte of the configuration port.
`default_nettype none

module scrp_core (
	input  var scrp_pkg::state_t st,
	input  var scrp_pkg::in_t    item,
	output var scrp_pkg::state_t st_n,
	output var scrp_pkg::out_t   res
);

	logic [7:0]  sel;
	logic [2:0]  bc;
	logic [2:0]  bc_inc;
	logic [7:0]  rd;
	logic        done;
	logic [15:0] val16;
	logic [15:0] cmp16;

	always_comb begin
		st_n   = st;
		rd     = 8'd0;
		done   = 1'b0;
		sel    = st.selected_item;
		bc     = item.start_req ? 3'd0 : st.byte_count;
		bc_inc = (bc < scrp_pkg::COUNT_MAX) ? bc + 3'd1 : bc;
		val16  = 16'd0;
		cmp16  = 16'd0;
		if (item.func == scrp_pkg::FUNC_TRANSMIT) begin
			st_n.byte_count = bc;
			unique case (sel)
				scrp_pkg::ITEM_CLK_CAL: begin
					rd = st.clock_cal_value;
					st_n.selected_item = scrp_pkg::ITEM_NONE;
				end
				scrp_pkg::ITEM_WR_EN: begin
					rd = {7'd0, st.write_enable_flag};
					st_n.selected_item = scrp_pkg::ITEM_NONE;
				end
				scrp_pkg::ITEM_DEBUG: begin
					rd = {6'd0, st.debug_code};
					st_n.selected_item = scrp_pkg::ITEM_NONE;
				end
				scrp_pkg::ITEM_TIMEOUT: begin
					if (bc == 3'd0) begin
						st_n.byte_buffer[0] = st.timeout_value[7:0];
						st_n.byte_buffer[1] = st.timeout_value[15:8];
					end
					rd = st_n.byte_buffer[bc[1:0]];
					st_n.byte_count = bc_inc;
					if (bc_inc >= scrp_pkg::SHORT_LEN) begin
						st_n.selected_item = scrp_pkg::ITEM_NONE;
					end
				end
				default: begin
				end
			endcase
		end else begin
			if (item.start_req) begin
				sel = scrp_pkg::ITEM_NONE;
			end
			st_n.byte_count = bc;
			st_n.selected_item = sel;
			if (sel == scrp_pkg::ITEM_NONE) begin
				st_n.selected_item = item.data_byte;
				st_n.byte_count = 3'd0;
			end else if (sel <= scrp_pkg::ITEM_TIMEOUT) begin
				if (bc < scrp_pkg::LONG_LEN) begin
					st_n.byte_buffer[bc[1:0]] = item.data_byte;
				end
				st_n.byte_count = bc_inc;
				if (sel == scrp_pkg::ITEM_TIMEOUT) begin
					if (bc_inc >= scrp_pkg::LONG_LEN) begin
						val16 = {st_n.byte_buffer[1], st_n.byte_buffer[0]};
						cmp16 = ~{st_n.byte_buffer[3], st_n.byte_buffer[2]};
						if (val16 == cmp16) begin
							st_n.timeout_value = val16;
							done = 1'b1;
						end
						st_n.selected_item = scrp_pkg::ITEM_NONE;
					end
				end else if (bc_inc >= scrp_pkg::SHORT_LEN) begin
					if (st_n.byte_buffer[0] == ~st_n.byte_buffer[1]) begin
						if (sel == scrp_pkg::ITEM_CLK_CAL) begin
							st_n.clock_cal_value = st_n.byte_buffer[0];
							done = 1'b1;
						end else if (sel == scrp_pkg::ITEM_WR_EN) begin
							if (st_n.byte_buffer[0] <= scrp_pkg::WR_EN_MAX) begin
								st_n.write_enable_flag = st_n.byte_buffer[0][0];
								done = 1'b1;
							end
						end else begin
							if (st_n.byte_buffer[0] <= scrp_pkg::DEBUG_MAX) begin
								st_n.debug_code = st_n.byte_buffer[0][1:0];
								done = 1'b1;
							end
						end
					end
					st_n.selected_item = scrp_pkg::ITEM_NONE;
				end
			end
		end
		res.read_data           = rd;
		res.committed           = done;
		res.clock_cal           = st_n.clock_cal_value;
		res.eeprom_write_enable = st_n.write_enable_flag;
		res.debug_mode          = st_n.debug_code;
		res.tx_timeout          = st_n.timeout_value;
	end

endmodule

`default_nettype wire

/* hw/rtl/safe_config_register_port_unit.sv */
// Top level of the byte-level configuration port with complement-checked setting writes.
`default_nettype none

// The block takes one bus byte per transaction on the input channel and gives
// one result transaction per byte on the output channel. A write sequence
// selects a setting (1 clock calibration, 2 write enable, 3 debug mode,
// 4 timeout) and commits a value only when it is followed by its bitwise
// complement; a read sequence returns the selected setting, low byte first.
// Every result also carries the current values of all four settings. The
// block sustains one transaction per clock cycle while the output is not
// stalled; each byte passes through the input register and then the result register, with
// all state updated by a single pass of logic between them. A stalled output
// holds both registers, and the input channel is ready whenever the input
// register is empty or moves forward in the same cycle. All settings reset to
// zero and no setting is selected after reset.
module safe_config_register_port_unit (
	input  var logic            clk,
	input  var logic            arst_n,
	input  var logic            in_valid,
	output var logic            in_ready,
	input  var scrp_pkg::in_t   in_item,
	output var logic            out_valid,
	input  var logic            out_ready,
	output var scrp_pkg::out_t  out_item
);

	logic             valid_s1;
	scrp_pkg::in_t    item_s1;
	logic             out_valid_q;
	scrp_pkg::out_t   out_q;
	scrp_pkg::state_t st_q;
	scrp_pkg::state_t st_n;
	scrp_pkg::out_t   res;
	logic             advance;

	// The input stage moves on whenever the result register is free or drains now.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Decoding of the byte and all setting updates happen in the core.
	scrp_core u_core (
		.st   (st_q),
		.item (item_s1),
		.st_n (st_n),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				st_q <= st_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	// A commit can only come from a written byte.
	a_commit_on_receive: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && res.committed) |-> (item_s1.func == scrp_pkg::FUNC_RECEIVE))
		else $error("commit reported on a transmit transaction");

	// A setting changes only together with a reported commit.
	a_change_needs_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && ((st_n.timeout_value != st_q.timeout_value) ||
			(st_n.clock_cal_value != st_q.clock_cal_value) ||
			(st_n.write_enable_flag != st_q.write_enable_flag) ||
			(st_n.debug_code != st_q.debug_code))) |-> res.committed)
		else $error("setting changed without a commit");

	// The byte counter never runs past a full four-byte value.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.byte_count <= scrp_pkg::LONG_LEN)
		else $error("byte counter beyond four");

	// The debug code register only ever holds a legal code.
	a_debug_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.debug_mode <= scrp_pkg::DEBUG_MAX[1:0]))
		else $error("illegal debug code reported");
`endif

endmodule

`default_nettype wire
